[rtl/spf_pkg.sv]
// Shared types and constants of the smallest-prime-factor factorizer.
package spf_pkg;

  localparam int VAL_W           = 18;
  localparam int MAX_RES         = 6;
  localparam int RES_CNT_W       = 3;
  localparam int MAX_VALUE_DEF   = 262144;
  localparam int PRIME_SLOTS_DEF = 23000;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 40;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = 2;

  localparam logic [1:0] KIND_NORM = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       kind;
  } qitem_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  typedef struct packed {
    logic [VAL_W-1:0] prime;
    logic [VAL_W-1:0] radical;
    logic             last;
    logic             bad;
  } result_t;

endpackage

[rtl/spf_front.sv]
// Input stage: classifies values and queues them for the factoring engine.
module spf_front #(
  parameter int MAX_VALUE = spf_pkg::MAX_VALUE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spf_pkg::IN_TDATA_W-1:0]   in_tdata,
  output spf_pkg::qhead_t                  head,
  input  logic                             pop
);

  localparam int CW = 26;

  spf_pkg::qitem_t                  q_mem_r [spf_pkg::QUEUE_DEPTH];
  logic [spf_pkg::QUEUE_AW-1:0]     wp_r, rp_r;
  logic [spf_pkg::QUEUE_AW:0]       cnt_r;
  logic [spf_pkg::VAL_W-1:0]        v;
  spf_pkg::qitem_t                  item;
  logic                             push, take;

  assign v         = in_tdata[spf_pkg::VAL_W-1:0];
  assign in_tready = (cnt_r != (spf_pkg::QUEUE_AW+1)'(spf_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign take      = pop && (cnt_r != '0);

  always_comb begin
    item.value = v;
    if (v == '0 || CW'(v) >= CW'(MAX_VALUE)) begin
      item.kind = spf_pkg::KIND_BAD;
    end else if (v == spf_pkg::VAL_W'(1)) begin
      item.kind = spf_pkg::KIND_ONE;
    end else begin
      item.kind = spf_pkg::KIND_NORM;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (take) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (spf_pkg::QUEUE_AW+1)'(push) - (spf_pkg::QUEUE_AW+1)'(take);
    end
  end

endmodule

[rtl/spf_div.sv]
// Restoring divider, one quotient bit per cycle.
module spf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spf_pkg::VAL_W-1:0]  dividend,
  input  logic [spf_pkg::VAL_W-1:0]  divisor,
  output logic                       done,
  output logic [spf_pkg::VAL_W-1:0]  quotient
);

  localparam int W  = spf_pkg::VAL_W;
  localparam int NW = $clog2(W + 1);

  logic [W-1:0]  q_r, r_r, d_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial, diff;

  assign trial    = {r_r, q_r[W-1]};
  assign diff     = trial - {1'b0, d_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_r <= diff[W-1:0];
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= trial[W-1:0];
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/spf_back.sv]
// Sieve, factor table and factoring sequencer with the result register.
module spf_back #(
  parameter int MAX_VALUE   = spf_pkg::MAX_VALUE_DEF,
  parameter int PRIME_SLOTS = spf_pkg::PRIME_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spf_pkg::qhead_t                   head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  localparam int VW  = $clog2(MAX_VALUE);
  localparam int PW  = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int CNW = $clog2(PRIME_SLOTS + 1);
  localparam int MW  = (VW > spf_pkg::VAL_W) ? VW : spf_pkg::VAL_W;
  localparam int W   = spf_pkg::VAL_W;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_SV_RD  = 4'd1;
  localparam logic [3:0] S_SV_CHK = 4'd2;
  localparam logic [3:0] S_SV_PL  = 4'd3;
  localparam logic [3:0] S_SV_PW  = 4'd4;
  localparam logic [3:0] S_SV_MW  = 4'd5;
  localparam logic [3:0] S_IDLE   = 4'd6;
  localparam logic [3:0] S_F_RD   = 4'd7;
  localparam logic [3:0] S_F_LK   = 4'd8;
  localparam logic [3:0] S_F_MUL  = 4'd9;
  localparam logic [3:0] S_F_DIV  = 4'd10;
  localparam logic [3:0] S_F_FIN  = 4'd11;
  localparam logic [3:0] S_PUSH   = 4'd12;

  logic [VW-1:0] spf_mem   [MAX_VALUE];
  logic [VW-1:0] plist_mem [PRIME_SLOTS];

  logic [3:0]     st_r, st_nxt, ret_r, ret_nxt;
  logic [VW-1:0]  i_r, i_nxt, clr_r, clr_nxt, spf_i_r, spf_i_nxt;
  logic [VW-1:0]  sp_r, sp_nxt;
  logic [CNW-1:0] pcnt_r, pcnt_nxt, j_r, j_nxt;
  logic [2*VW-1:0] m_r, m_nxt;
  logic [W-1:0]   v_r, v_nxt, p_r, p_nxt, prev_r, prev_nxt, pend_r, pend_nxt;
  logic [W-1:0]   rad_r, rad_nxt;
  logic [spf_pkg::RES_CNT_W-1:0] n_r, n_nxt;
  logic           new_r, new_nxt;
  spf_pkg::result_t res_r, res_nxt, out_r;
  logic           ov_r;

  logic           spf_we, pl_we;
  logic [VW-1:0]  spf_wa, spf_wd, spf_ra, spf_rd_r, pl_wd, pl_rd_r;
  logic [PW-1:0]  pl_wa, pl_ra;

  logic           div_start, div_done;
  logic [W-1:0]   div_q;
  logic           slot_free, load_out;
  logic [MW-1:0]  lk_p, lk_v;
  logic [2*W-1:0] rad_prod;

  assign slot_free = !ov_r || out_tready;
  assign lk_p      = MW'(spf_rd_r);
  assign lk_v      = MW'(v_r);
  assign rad_prod  = rad_r * p_r;

  always_ff @(posedge clk) begin
    if (spf_we) spf_mem[spf_wa] <= spf_wd;
    spf_rd_r <= spf_mem[spf_ra];
  end

  always_ff @(posedge clk) begin
    if (pl_we) plist_mem[pl_wa] <= pl_wd;
    pl_rd_r <= plist_mem[pl_ra];
  end

  spf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (v_r),
    .divisor  (p_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    i_nxt     = i_r;
    clr_nxt   = clr_r;
    spf_i_nxt = spf_i_r;
    sp_nxt    = sp_r;
    pcnt_nxt  = pcnt_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    v_nxt     = v_r;
    p_nxt     = p_r;
    prev_nxt  = prev_r;
    pend_nxt  = pend_r;
    rad_nxt   = rad_r;
    n_nxt     = n_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    spf_we    = 1'b0;
    spf_wa    = clr_r;
    spf_wd    = '0;
    spf_ra    = (st_r == S_F_RD) ? VW'(v_r) : i_r;
    pl_we     = 1'b0;
    pl_wa     = pcnt_r[PW-1:0];
    pl_wd     = i_r;
    pl_ra     = j_r[PW-1:0];
    div_start = 1'b0;
    pop       = 1'b0;
    load_out  = 1'b0;

    case (st_r)
      S_CLR: begin
        spf_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == VW'(MAX_VALUE - 1)) begin
          i_nxt  = VW'(2);
          st_nxt = S_SV_RD;
        end
      end
      S_SV_RD: st_nxt = S_SV_CHK;
      S_SV_CHK: begin
        j_nxt = '0;
        if (spf_rd_r == '0) begin
          spf_we    = 1'b1;
          spf_wa    = i_r;
          spf_wd    = i_r;
          spf_i_nxt = i_r;
          if (pcnt_r < CNW'(PRIME_SLOTS)) begin
            pl_we    = 1'b1;
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end else begin
          spf_i_nxt = spf_rd_r;
        end
        st_nxt = S_SV_PL;
      end
      S_SV_PL: begin
        if (j_r >= pcnt_r) begin
          if (i_r == VW'(MAX_VALUE - 1)) begin
            st_nxt = S_IDLE;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_SV_RD;
          end
        end else begin
          st_nxt = S_SV_PW;
        end
      end
      S_SV_PW: begin
        m_nxt  = pl_rd_r * i_r;
        sp_nxt = pl_rd_r;
        st_nxt = S_SV_MW;
      end
      S_SV_MW: begin
        if (m_r >= (2*VW)'(MAX_VALUE) || sp_r == spf_i_r) begin
          if (m_r < (2*VW)'(MAX_VALUE)) begin
            spf_we = 1'b1;
            spf_wa = m_r[VW-1:0];
            spf_wd = sp_r;
          end
          if (i_r == VW'(MAX_VALUE - 1)) begin
            st_nxt = S_IDLE;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_SV_RD;
          end
        end else begin
          spf_we = 1'b1;
          spf_wa = m_r[VW-1:0];
          spf_wd = sp_r;
          j_nxt  = j_r + 1'b1;
          st_nxt = S_SV_PL;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.kind)
            spf_pkg::KIND_BAD: begin
              res_nxt = '{prime: '0, radical: '0, last: 1'b1, bad: 1'b1};
              ret_nxt = S_IDLE;
              st_nxt  = S_PUSH;
            end
            spf_pkg::KIND_ONE: begin
              res_nxt = '{prime: '0, radical: W'(1), last: 1'b1, bad: 1'b0};
              ret_nxt = S_IDLE;
              st_nxt  = S_PUSH;
            end
            default: begin
              v_nxt    = head.item.value;
              prev_nxt = '0;
              n_nxt    = '0;
              rad_nxt  = W'(1);
              st_nxt   = S_F_RD;
            end
          endcase
        end
      end
      S_F_RD: st_nxt = (v_r == W'(1)) ? S_F_FIN : S_F_LK;
      S_F_LK: begin
        if (lk_p < MW'(2) || lk_p > lk_v) p_nxt = v_r;
        else p_nxt = W'(spf_rd_r);
        if (p_nxt != prev_r) begin
          if (n_r >= spf_pkg::RES_CNT_W'(spf_pkg::MAX_RES)) begin
            st_nxt = S_F_FIN;
          end else begin
            new_nxt  = 1'b1;
            pend_nxt = p_nxt;
            prev_nxt = p_nxt;
            n_nxt    = n_r + 1'b1;
            if (n_r != '0) begin
              res_nxt = '{prime: pend_r, radical: '0, last: 1'b0, bad: 1'b0};
              ret_nxt = S_F_MUL;
              st_nxt  = S_PUSH;
            end else begin
              st_nxt = S_F_MUL;
            end
          end
        end else begin
          new_nxt = 1'b0;
          st_nxt  = S_F_MUL;
        end
      end
      S_F_MUL: begin
        if (new_r) rad_nxt = rad_prod[W-1:0];
        div_start = 1'b1;
        st_nxt    = S_F_DIV;
      end
      S_F_DIV: begin
        if (div_done) begin
          v_nxt  = div_q;
          st_nxt = S_F_RD;
        end
      end
      S_F_FIN: begin
        res_nxt = '{prime: pend_r, radical: rad_r, last: 1'b1, bad: 1'b0};
        ret_nxt = S_IDLE;
        st_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) begin
          load_out = 1'b1;
          st_nxt   = ret_r;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    spf_i_r <= spf_i_nxt;
    sp_r    <= sp_nxt;
    j_r     <= j_nxt;
    m_r     <= m_nxt;
    v_r     <= v_nxt;
    p_r     <= p_nxt;
    prev_r  <= prev_nxt;
    pend_r  <= pend_nxt;
    rad_r   <= rad_nxt;
    n_r     <= n_nxt;
    new_r   <= new_nxt;
    res_r   <= res_nxt;
    ret_r   <= ret_nxt;
    if (load_out) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      pcnt_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      pcnt_r <= pcnt_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0, out_r.radical, out_r.prime};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.bad;

endmodule

[rtl/spf_sieve_prime_factorizer.sv]
// Top level of the smallest-prime-factor sieve and factorizer.
//
//  channel | dir | ports                         | contents
//  in      | in  | in_tvalid/in_tready/in_tdata  | value
//  out     | out | out_tvalid/out_tready/out_*   | prime, radical, last, bad
//
// After reset the table is cleared, then sieved; inputs queue up but are
// not factored until then. A zero, out-of-range or one value needs no
// lookup. Other values take one table lookup and one division by the
// bit-serial divider per prime factor, with multiplicity; up to 17 lookups.
// A stalled output holds the engine; the 4-entry queue keeps taking inputs
// until it is full.
module spf_sieve_prime_factorizer #(
  parameter int MAX_VALUE   = spf_pkg::MAX_VALUE_DEF,
  parameter int PRIME_SLOTS = spf_pkg::PRIME_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spf_pkg::IN_TDATA_W-1:0]   in_tdata,   // [17:0] value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [17:0] prime, [35:18] radical
  output logic                             out_tlast,
  output logic                             out_tuser   // [0] bad_value
);

  spf_pkg::qhead_t head;
  logic            pop;

  spf_front #(.MAX_VALUE(MAX_VALUE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  spf_back #(.MAX_VALUE(MAX_VALUE), .PRIME_SLOTS(PRIME_SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/spf_chk.sv]
// Port-level checks of the factorizer, bound to the top level.
module spf_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tlast,
  input logic                             out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("bad value result malformed");

  a_mid_rad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[35:18] == '0 && !out_tuser)
    else $error("radical on non-final result");

endmodule

bind spf_sieve_prime_factorizer spf_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[tb/tb_spf_sieve_prime_factorizer.sv]
// Testbench: streams values into the factorizer and checks every prime/radical result.
`timescale 1ns / 1ps

module tb_spf_sieve_prime_factorizer;

  localparam int TABLE_SIZE = spf_pkg::MAX_VALUE_DEF;
  localparam int VW         = spf_pkg::VAL_W;

  class factor_scoreboard;
    int unsigned      smallest_factor[];
    int unsigned      prime_store[$];
    spf_pkg::result_t pending_results[$];
    int               mismatches;

    function new();
      int unsigned m;
      mismatches = 0;
      smallest_factor = new[TABLE_SIZE];
      foreach (smallest_factor[k]) smallest_factor[k] = 0;
      for (int unsigned i = 2; i < TABLE_SIZE; i++) begin
        if (smallest_factor[i] == 0) begin
          smallest_factor[i] = i;
          if (prime_store.size() < spf_pkg::PRIME_SLOTS_DEF)
            prime_store.insert(prime_store.size(), i);
        end
        foreach (prime_store[j]) begin
          if (longint'(prime_store[j]) * i >= TABLE_SIZE) break;
          m = prime_store[j] * i;
          smallest_factor[m] = prime_store[j];
          if (i % prime_store[j] == 0) break;
        end
      end
    endfunction

    function void note_value(logic [VW-1:0] value);
      spf_pkg::result_t r;
      int unsigned v, p, prev, rad, n;
      r = '0;
      r.last = 1'b1;
      if (value == '0 || 32'(value) >= TABLE_SIZE) begin
        r.bad = 1'b1;
        pending_results.insert(pending_results.size(), r);
        return;
      end
      if (value == VW'(1)) begin
        r.radical = VW'(1);
        pending_results.insert(pending_results.size(), r);
        return;
      end
      v = 32'(value);
      prev = 0;
      rad = 1;
      n = 0;
      while (v > 1) begin
        p = smallest_factor[v];
        if (p < 2 || p > v) p = v;
        if (p != prev) begin
          if (n >= spf_pkg::MAX_RES) break;
          r = '0;
          r.prime = VW'(p);
          pending_results.insert(pending_results.size(), r);
          rad = rad * p;
          prev = p;
          n++;
        end
        v = v / p;
      end
      pending_results[$].radical = VW'(rad);
      pending_results[$].last = 1'b1;
    endfunction

    function void check_result(spf_pkg::result_t got);
      spf_pkg::result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: prime %0d radical %0d last %0b bad %0b",
                   got.prime, got.radical, got.last, got.bad);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp prime %0d radical %0d last %0b bad %0b, got %0d %0d %0b %0b",
                   want.prime, want.radical, want.last, want.bad,
                   got.prime, got.radical, got.last, got.bad);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [spf_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [spf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  factor_scoreboard sb;

  spf_sieve_prime_factorizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int burst_left = 0;

  task automatic send_value(input logic [VW-1:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(spf_pkg::IN_TDATA_W-VW){1'b0}}, value};
    do @(posedge clk); while (!in_tready);
    sb.note_value(value);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] random_value();
    int unsigned v, p;
    case ($urandom_range(0, 5))
      0: return VW'($urandom_range(0, 50));
      1: begin
        v = 1;
        repeat ($urandom_range(1, 17)) begin
          p = ($urandom_range(0, 3) == 0) ? 2 : (3 + 2 * $urandom_range(0, 10));
          if (v * p < TABLE_SIZE) v = v * p;
        end
        return VW'(v);
      end
      2: begin
        p = sb.prime_store[$urandom_range(0, sb.prime_store.size() - 1)];
        return VW'(p);
      end
      default: return VW'($urandom_range(0, TABLE_SIZE - 1));
    endcase
  endfunction

  // Receiver stall pattern: modes of free flow, light and heavy backpressure.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    spf_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.prime   = out_tdata[VW-1:0];
      got.radical = out_tdata[2*VW-1:VW];
      got.last    = out_tlast;
      got.bad     = out_tuser;
      sb.check_result(got);
    end
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [VW-1:0] directed[$];
    int wait_cycles;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{0, 1, 2, 3, 4, 6, 30030, 240240, 131072, 177147, 65536,
                 262139, 262143, 262142, 223092, 510, 9699, 49, 97, 255255};
    foreach (directed[k]) send_value(directed[k]);
    drain();

    repeat (210) send_value(random_value());
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (500) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
